/* rtl/tpm_pkg.sv */
`default_nettype none
package tpm_pkg;

  localparam int SIDE_W   = 16;
  localparam int FRAC_W   = 8;
  localparam int STAT_W   = 2;
  localparam int PER_W    = 18;
  localparam int AREA_W   = 24;
  localparam int ANG_W    = 16;
  localparam int VOL_W    = 32;
  localparam int SURF_W   = 26;
  localparam int SQ_W     = 2 * SIDE_W;
  localparam int XS_W     = SQ_W + 3;
  localparam int P12_W    = PER_W + SIDE_W + 1;
  localparam int P34_W    = 2 * (SIDE_W + 1);
  localparam int PLO_W    = SIDE_W + 1;
  localparam int PP_W     = P12_W + PLO_W;
  localparam int Q_W      = 70;
  localparam int ROOT_W   = 35;
  localparam int VOLP_W   = AREA_W + SIDE_W;
  localparam int LATP_W   = PER_W + SIDE_W;
  localparam int X_W      = 40;
  localparam int Z_W      = 26;
  localparam int CORDIC_STEPS = 23;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 152;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_TRI    = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_HEIGHT = 2'd2;

  localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd5898240;
  localparam logic signed [Z_W-1:0] Z_HALF    = 26'sd11796480;

  localparam logic signed [Z_W-1:0] ATAN_DEG [CORDIC_STEPS] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304, 26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667,
    26'sd1833, 26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1
  };

  typedef struct packed {
    logic signed [XS_W-1:0] xa;
    logic signed [XS_W-1:0] xb;
    logic signed [XS_W-1:0] xc;
    logic [PER_W-1:0]       per;
    logic [SIDE_W-1:0]      h;
    logic [STAT_W-1:0]      status;
  } sq_tag_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PER_W-1:0]  per;
    logic [AREA_W-1:0] area;
    logic [VOLP_W-1:0] volp;
    logic [LATP_W-1:0] latp;
  } side_t;

  function automatic logic signed [X_W-1:0] mag_shr(input logic signed [X_W-1:0] v,
                                                    input logic [4:0] sh);
    logic [X_W-1:0] m;
    m = v[X_W-1] ? X_W'(-v) : X_W'(v);
    m = m >> sh;
    return v[X_W-1] ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

/* rtl/tpm_isqrt.sv */
`default_nettype none
module tpm_isqrt #(
  parameter int TAG_W = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [tpm_pkg::Q_W-1:0]     in_q,
  input  wire logic [TAG_W-1:0]            in_tag,
  output logic                             out_valid,
  output logic [tpm_pkg::ROOT_W-1:0]       out_root,
  output logic [TAG_W-1:0]                 out_tag
);

  localparam int N = tpm_pkg::ROOT_W;

  logic                         v_r    [N];
  logic [tpm_pkg::Q_W-1:0]      rem_r  [N];
  logic [tpm_pkg::ROOT_W-1:0]   root_r [N];
  logic [TAG_W-1:0]             tag_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_bit
    localparam int B = N - 1 - k;
    logic                       v_in;
    logic [tpm_pkg::Q_W-1:0]    rem_in;
    logic [tpm_pkg::ROOT_W-1:0] root_in;
    logic [TAG_W-1:0]           tag_in;
    logic [tpm_pkg::Q_W-1:0]    trial;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_q;
      assign root_in = '0;
      assign tag_in  = in_tag;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign tag_in  = tag_r[k-1];
    end

    assign trial = (tpm_pkg::Q_W'(root_in) << (B + 1)) |
                   (tpm_pkg::Q_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_in;
        if (rem_in >= trial) begin
          rem_r[k]  <= rem_in - trial;
          root_r[k] <= root_in | (tpm_pkg::ROOT_W'(1) << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_tag   = tag_r[N-1];

endmodule
`default_nettype wire

/* rtl/tpm_cordic.sv */
`default_nettype none
module tpm_cordic #(
  parameter int TAG_W = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [tpm_pkg::XS_W-1:0]   in_x [3],
  input  wire logic [tpm_pkg::ROOT_W-1:0]        in_y,
  input  wire logic [TAG_W-1:0]                  in_tag,
  output logic                                   out_valid,
  output logic [tpm_pkg::ANG_W-1:0]              out_angle [3],
  output logic [TAG_W-1:0]                       out_tag
);

  localparam int S = tpm_pkg::CORDIC_STEPS;

  logic                            v_r   [S+1];
  logic [TAG_W-1:0]                tag_r [S+1];
  logic signed [tpm_pkg::X_W-1:0]  x_r   [3][S+1];
  logic signed [tpm_pkg::X_W-1:0]  y_r   [3][S+1];
  logic signed [tpm_pkg::Z_W-1:0]  z_r   [3][S+1];
  logic                            fv_r;
  logic [TAG_W-1:0]                ftag_r;
  logic [tpm_pkg::ANG_W-1:0]       ang_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
    end
  end

  for (genvar k = 1; k <= S; k++) begin : g_vstep
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k] <= tag_r[k-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic signed [tpm_pkg::X_W-1:0] x0;
    logic signed [tpm_pkg::X_W-1:0] y0;

    assign x0 = tpm_pkg::X_W'(in_x[l]);
    assign y0 = $signed(tpm_pkg::X_W'(in_y));

    always_ff @(posedge clk) begin
      if (en) begin
        if (x0 < 0) begin
          x_r[l][0] <= y0;
          y_r[l][0] <= -x0;
          z_r[l][0] <= tpm_pkg::Z_QUARTER;
        end else begin
          x_r[l][0] <= x0;
          y_r[l][0] <= y0;
          z_r[l][0] <= '0;
        end
      end
    end

    for (genvar k = 0; k < S; k++) begin : g_step
      logic signed [tpm_pkg::X_W-1:0] dx;
      logic signed [tpm_pkg::X_W-1:0] dy;
      assign dx = tpm_pkg::mag_shr(y_r[l][k], 5'(k));
      assign dy = tpm_pkg::mag_shr(x_r[l][k], 5'(k));

      always_ff @(posedge clk) begin
        if (en) begin
          if (y_r[l][k] > 0) begin
            x_r[l][k+1] <= x_r[l][k] + dx;
            y_r[l][k+1] <= y_r[l][k] - dy;
            z_r[l][k+1] <= z_r[l][k] + tpm_pkg::ATAN_DEG[k];
          end else begin
            x_r[l][k+1] <= x_r[l][k] - dx;
            y_r[l][k+1] <= y_r[l][k] + dy;
            z_r[l][k+1] <= z_r[l][k] - tpm_pkg::ATAN_DEG[k];
          end
        end
      end
    end

    logic signed [tpm_pkg::Z_W-1:0] zc;
    always_comb begin
      if (z_r[l][S] < 0) begin
        zc = '0;
      end else if (z_r[l][S] > tpm_pkg::Z_HALF) begin
        zc = tpm_pkg::Z_HALF;
      end else begin
        zc = z_r[l][S];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ang_r[l] <= zc[tpm_pkg::ANG_W+7:8];
      end
    end

    assign out_angle[l] = ang_r[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (en) begin
      fv_r <= v_r[S];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ftag_r <= tag_r[S];
    end
  end

  assign out_valid = fv_r;
  assign out_tag   = ftag_r;

endmodule
`default_nettype wire

/* rtl/triangle_prism_metrics_core.sv */
`default_nettype none
// Triangle and prism metrics, one item per cycle while input ready is high. Each transfer
// carries three Q8.8 sides and a Q8.8 height; the result gives status, perimeter, Heron
// area, the three angles in degrees and the prism volume and surface area, all truncated.
// The pipeline runs from input transfer to result through four stages of squares and
// products, 35 stages of a one-bit-per-stage square root, one stage for area scaling, 25
// stages of three parallel CORDIC lanes and the output register. Input ready is registered
// and drops only when the output is stalled and the skid stage behind it is full.
module triangle_prism_metrics_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // side_a, side_b, side_c, prism_height
  input  wire logic [tpm_pkg::IN_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // status, perimeter, area, angle_a, angle_b, angle_c, volume, surface_area, zero pad
  output logic [tpm_pkg::OUT_W-1:0]        out_tdata
);

  localparam int SW = tpm_pkg::SIDE_W;

  logic en;

  logic [SW-1:0]     a, b, c, h;
  logic [SW:0]       sab, sac, sbc;
  logic              tri_ok;

  logic                      s1_v_r;
  logic [tpm_pkg::STAT_W-1:0] s1_status_r;
  logic [tpm_pkg::PER_W-1:0] s1_per_r;
  logic [SW-1:0]             s1_h_r;
  logic [tpm_pkg::PER_W-1:0] s1_f1_r;
  logic [SW:0]               s1_f2_r, s1_f3_r, s1_f4_r;
  logic [tpm_pkg::SQ_W-1:0]  s1_aa_r, s1_bb_r, s1_cc_r;

  logic                      s2_v_r;
  tpm_pkg::sq_tag_t          s2_tag_r;
  logic [tpm_pkg::P12_W-1:0] s2_p12_r;
  logic [tpm_pkg::P34_W-1:0] s2_p34_r;

  logic                      s3_v_r;
  tpm_pkg::sq_tag_t          s3_tag_r;
  logic [tpm_pkg::PP_W-1:0]  s3_pl_r, s3_ph_r;

  logic                      s4_v_r;
  tpm_pkg::sq_tag_t          s4_tag_r;
  logic [tpm_pkg::Q_W-1:0]   s4_q_r;

  logic                       sq_v;
  logic [tpm_pkg::ROOT_W-1:0] sq_root;
  tpm_pkg::sq_tag_t           sq_tag;
  logic [tpm_pkg::AREA_W-1:0] sq_area;

  logic                                s5_v_r;
  logic [tpm_pkg::ROOT_W-1:0]          s5_root_r;
  logic signed [tpm_pkg::XS_W-1:0]     s5_x_r [3];
  tpm_pkg::side_t                      s5_side_r;

  logic                      cv;
  logic [tpm_pkg::ANG_W-1:0] cang [3];
  tpm_pkg::side_t            cside;

  logic [tpm_pkg::VOL_W-1:0]  res_vol;
  logic [tpm_pkg::SURF_W:0]   surf_sum;
  logic [tpm_pkg::SURF_W-1:0] res_surf;
  logic [tpm_pkg::OUT_W-1:0]  res;

  logic                       out_v_r, skid_v_r;
  logic [tpm_pkg::OUT_W-1:0]  out_data_r, skid_data_r;

  assign en        = !skid_v_r;
  assign in_tready = en;

  assign a = in_tdata[SW-1:0];
  assign b = in_tdata[2*SW-1:SW];
  assign c = in_tdata[3*SW-1:2*SW];
  assign h = in_tdata[4*SW-1:3*SW];

  assign sab    = (SW+1)'(a) + (SW+1)'(b);
  assign sac    = (SW+1)'(a) + (SW+1)'(c);
  assign sbc    = (SW+1)'(b) + (SW+1)'(c);
  assign tri_ok = (sab > (SW+1)'(c)) && (sac > (SW+1)'(b)) && (sbc > (SW+1)'(a));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!tri_ok) begin
        s1_status_r <= tpm_pkg::ST_NOT_TRI;
      end else if (h == '0) begin
        s1_status_r <= tpm_pkg::ST_BAD_HEIGHT;
      end else begin
        s1_status_r <= tpm_pkg::ST_OK;
      end
      s1_per_r <= tpm_pkg::PER_W'(sab) + tpm_pkg::PER_W'(c);
      s1_h_r   <= h;
      s1_f1_r  <= tpm_pkg::PER_W'(sab) + tpm_pkg::PER_W'(c);
      s1_f2_r  <= (sbc > (SW+1)'(a)) ? sbc - (SW+1)'(a) : '0;
      s1_f3_r  <= (sac > (SW+1)'(b)) ? sac - (SW+1)'(b) : '0;
      s1_f4_r  <= (sab > (SW+1)'(c)) ? sab - (SW+1)'(c) : '0;
      s1_aa_r  <= tpm_pkg::SQ_W'(a) * tpm_pkg::SQ_W'(a);
      s1_bb_r  <= tpm_pkg::SQ_W'(b) * tpm_pkg::SQ_W'(b);
      s1_cc_r  <= tpm_pkg::SQ_W'(c) * tpm_pkg::SQ_W'(c);

      s2_tag_r.xa     <= $signed(tpm_pkg::XS_W'(s1_bb_r)) + $signed(tpm_pkg::XS_W'(s1_cc_r))
                         - $signed(tpm_pkg::XS_W'(s1_aa_r));
      s2_tag_r.xb     <= $signed(tpm_pkg::XS_W'(s1_aa_r)) + $signed(tpm_pkg::XS_W'(s1_cc_r))
                         - $signed(tpm_pkg::XS_W'(s1_bb_r));
      s2_tag_r.xc     <= $signed(tpm_pkg::XS_W'(s1_aa_r)) + $signed(tpm_pkg::XS_W'(s1_bb_r))
                         - $signed(tpm_pkg::XS_W'(s1_cc_r));
      s2_tag_r.per    <= s1_per_r;
      s2_tag_r.h      <= s1_h_r;
      s2_tag_r.status <= s1_status_r;
      s2_p12_r <= tpm_pkg::P12_W'(s1_f1_r) * tpm_pkg::P12_W'(s1_f2_r);
      s2_p34_r <= tpm_pkg::P34_W'(s1_f3_r) * tpm_pkg::P34_W'(s1_f4_r);

      s3_tag_r <= s2_tag_r;
      s3_pl_r  <= tpm_pkg::PP_W'(s2_p12_r) * tpm_pkg::PP_W'(s2_p34_r[tpm_pkg::PLO_W-1:0]);
      s3_ph_r  <= tpm_pkg::PP_W'(s2_p12_r) *
                  tpm_pkg::PP_W'(s2_p34_r[tpm_pkg::P34_W-1:tpm_pkg::PLO_W]);

      s4_tag_r <= s3_tag_r;
      s4_q_r   <= tpm_pkg::Q_W'(s3_pl_r) + (tpm_pkg::Q_W'(s3_ph_r) << tpm_pkg::PLO_W);
    end
  end

  tpm_isqrt #(
    .TAG_W ($bits(tpm_pkg::sq_tag_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_q      (s4_q_r),
    .in_tag    (s4_tag_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_tag   (sq_tag)
  );

  assign sq_area = sq_root[tpm_pkg::ROOT_W-1] ? '1 :
                   sq_root[tpm_pkg::ROOT_W-2:tpm_pkg::FRAC_W+2];

  always_ff @(posedge clk) begin
    if (en) begin
      s5_root_r        <= sq_root;
      s5_x_r[0]        <= sq_tag.xa;
      s5_x_r[1]        <= sq_tag.xb;
      s5_x_r[2]        <= sq_tag.xc;
      s5_side_r.status <= sq_tag.status;
      s5_side_r.per    <= sq_tag.per;
      s5_side_r.area   <= sq_area;
      s5_side_r.volp   <= tpm_pkg::VOLP_W'(sq_area) * tpm_pkg::VOLP_W'(sq_tag.h);
      s5_side_r.latp   <= tpm_pkg::LATP_W'(sq_tag.per) * tpm_pkg::LATP_W'(sq_tag.h);
    end
  end

  tpm_cordic #(
    .TAG_W ($bits(tpm_pkg::side_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_x      (s5_x_r),
    .in_y      (s5_root_r),
    .in_tag    (s5_side_r),
    .out_valid (cv),
    .out_angle (cang),
    .out_tag   (cside)
  );

  assign res_vol  = cside.volp[tpm_pkg::VOLP_W-1:tpm_pkg::FRAC_W];
  assign surf_sum = (tpm_pkg::SURF_W+1)'(cside.latp[tpm_pkg::LATP_W-1:tpm_pkg::FRAC_W]) +
                    (tpm_pkg::SURF_W+1)'({cside.area, 1'b0});
  assign res_surf = surf_sum[tpm_pkg::SURF_W] ? '1 : surf_sum[tpm_pkg::SURF_W-1:0];

  always_comb begin
    res = '0;
    res[1:0] = cside.status;
    if (cside.status != tpm_pkg::ST_NOT_TRI) begin
      res[19:2]  = cside.per;
      res[43:20] = cside.area;
      res[59:44] = cang[0];
      res[75:60] = cang[1];
      res[91:76] = cang[2];
    end
    if (cside.status == tpm_pkg::ST_OK) begin
      res[123:92]  = res_vol;
      res[149:124] = res_surf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_tready || !out_v_r) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= cv && en;
      end
    end else if (cv && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_tready || !out_v_r) begin
      out_data_r <= skid_v_r ? skid_data_r : res;
    end else if (cv && en) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_not_tri_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == tpm_pkg::ST_NOT_TRI |-> out_tdata[151:2] == '0)
    else $error("non-triangle result carries nonzero fields");

  a_bad_height_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == tpm_pkg::ST_BAD_HEIGHT |-> out_tdata[149:92] == '0)
    else $error("zero-height result carries prism fields");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[59:44] <= 16'd46080 && out_tdata[75:60] <= 16'd46080 &&
                   out_tdata[91:76] <= 16'd46080)
    else $error("angle above a half turn");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_tready |=> out_tvalid && !skid_v_r)
    else $error("skid stage did not drain into the output register");

endmodule
`default_nettype wire
